FILE: hw/rtl/rotating_bloom_dedup_unit_assert.svh
// Assertion macros shared by the dedup filter RTL
`ifndef ROTATING_BLOOM_DEDUP_UNIT_ASSERT_SVH
`define ROTATING_BLOOM_DEDUP_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RBD_CHECK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define RBD_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// condition must never hold
`define RBD_CHECK_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

FILE: hw/rtl/rbd_pkg.sv
// Shared types and constants for the rotating Bloom dedup filter
package rbd_pkg;

  // default geometry and register reset
  localparam int unsigned FILTER_BITS_DEF = 2048;
  localparam int unsigned NUM_SLOTS_DEF   = 4;
  localparam int unsigned CMD_DEPTH       = 2;
  localparam logic [31:0] WINDOW_RESET    = 32'd100;

  // widest bit position the filter allows (65536 bits)
  localparam int unsigned POS_W = 16;

  // hash multipliers
  localparam logic [31:0] HASH_A_MUL  = 32'h85EB_CA6B;
  localparam logic [31:0] HASH_A_TY   = 32'hC2B2_AE35;
  localparam logic [31:0] HASH_B_MUL  = 32'hCC9E_2D51;
  localparam logic [31:0] HASH_B_TY   = 32'h1B87_3593;
  localparam logic [31:0] HASH_C_MUL1 = 32'h7FEB_352D;
  localparam logic [31:0] HASH_C_MUL2 = 32'h846C_A68B;

  // one request
  typedef struct packed {
    logic [31:0] node_id;
    logic [31:0] seq_num;
    logic [7:0]  pkt_type;
    logic [31:0] now_tick;
  } rbd_in_t;

  // one result
  typedef struct packed {
    logic        is_new;
    logic [31:0] insert_count;
    logic [31:0] dup_count;
  } rbd_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic             rotate;
    logic [POS_W-1:0] pos0;
    logic [POS_W-1:0] pos1;
    logic [POS_W-1:0] pos2;
  } rbd_cmd_t;

endpackage

FILE: hw/rtl/rbd_ram.sv
// Generic single-write, single-read RAM with registered read data
module rbd_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/rbd_front.sv
// Front end: takes requests, decides slot rotation, computes the three bit positions
`include "rotating_bloom_dedup_unit_assert.svh"

module rbd_front
  import rbd_pkg::*;
#(
  parameter int unsigned FILTER_BITS = FILTER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        pkt_valid,
  output logic        pkt_ready,
  input  rbd_in_t     pkt,
  input  logic        init_busy,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output rbd_cmd_t    cmd
);

  localparam int unsigned IDX_W   = $clog2(FILTER_BITS);
  localparam int unsigned REM_W   = IDX_W + 1;
  localparam bit          IS_POW2 = (FILTER_BITS & (FILTER_BITS - 1)) == 0;
  // reciprocal of the bit count, scaled by 2^RSH and rounded down
  localparam int unsigned RSH     = 32 + IDX_W;
  localparam logic [32:0] RECIP   = 33'((64'd1 << RSH) / 64'(FILTER_BITS));
  localparam int unsigned STEPS   = 3;
  localparam int unsigned STEP_W  = $clog2(STEPS);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL1 = 5'b00010,
    F_MUL2 = 5'b00100,
    F_MOD  = 5'b01000,
    F_PUSH = 5'b10000
  } front_state_t;

  // low 32 bits of a product
  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] m;
    m = a * b;
    return m;
  endfunction

  // low bits of the quotient estimate; it is the true quotient or one below
  function automatic logic [REM_W-1:0] quo_low(input logic [31:0] h);
    logic [64:0] prod;
    prod = {33'd0, h} * {32'd0, RECIP};
    return REM_W'(prod >> RSH);
  endfunction

  // hash minus quotient times bit count, below twice the bit count
  function automatic logic [REM_W-1:0] rem_raw(input logic [31:0]      h,
                                               input logic [REM_W-1:0] q);
    logic [REM_W-1:0] qn;
    qn = q * REM_W'(FILTER_BITS);
    return h[REM_W-1:0] - qn;
  endfunction

  // one correcting subtract
  function automatic logic [REM_W-1:0] rem_fix(input logic [REM_W-1:0] r);
    return (r >= REM_W'(FILTER_BITS)) ? r - REM_W'(FILTER_BITS) : r;
  endfunction

  front_state_t      state;
  logic [31:0]       window_ticks;
  logic [31:0]       slot_start;
  logic [31:0]       id_q;
  logic [31:0]       sq_q;
  logic [7:0]        ty_q;
  logic              rot_q;
  logic [31:0]       ma1, ma2, mb1, mb2, mc;
  logic [31:0]       ha, hb, hc;
  logic [REM_W-1:0]  rem_a, rem_b, rem_c;
  logic [STEP_W-1:0] step_cnt;

  logic              accept;
  logic              rotate_now;
  logic [31:0]       elapsed;
  logic [31:0]       hc0, ha_pre, ha_mix, hb_pre, hb_mix, hc_mix, hc_mul;

  assign pkt_ready  = (state == F_IDLE) && !init_busy;
  assign accept     = pkt_valid && pkt_ready;
  assign elapsed    = pkt.now_tick - slot_start;
  assign rotate_now = elapsed > window_ticks;

  // hash mixing between the multiplier stages
  always_comb begin
    hc0    = {sq_q[23:0], ty_q} ^ id_q;
    ha_pre = id_q ^ ma1 ^ ma2;
    ha_mix = ha_pre ^ (ha_pre >> 16);
    hb_pre = sq_q ^ mb1 ^ mb2;
    hb_mix = hb_pre ^ (hb_pre >> 15);
    hc_mix = mc ^ (mc >> 15);
    hc_mul = mul32(hc_mix, HASH_C_MUL2);
  end

  // classified request to the queue
  assign cmd_valid = (state == F_PUSH);
  always_comb begin
    cmd.rotate = rot_q;
    if (IS_POW2) begin
      cmd.pos0 = POS_W'(ha[IDX_W-1:0]);
      cmd.pos1 = POS_W'(hb[IDX_W-1:0]);
      cmd.pos2 = POS_W'(hc[IDX_W-1:0]);
    end else begin
      cmd.pos0 = POS_W'(rem_a[IDX_W-1:0]);
      cmd.pos1 = POS_W'(rem_b[IDX_W-1:0]);
      cmd.pos2 = POS_W'(rem_c[IDX_W-1:0]);
    end
  end

  // window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_RESET;
    end else if (cfg_we) begin
      window_ticks <= cfg_wdata;
    end
  end

  // sequencer: accept, two multiply stages, three-step modulo unless FILTER_BITS is a power of two, push
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      slot_start <= '0;
      rot_q      <= 1'b0;
      step_cnt   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            id_q  <= pkt.node_id;
            sq_q  <= pkt.seq_num;
            ty_q  <= pkt.pkt_type;
            rot_q <= rotate_now;
            if (rotate_now) begin
              slot_start <= pkt.now_tick;
            end
            state <= F_MUL1;
          end
        end
        F_MUL1: begin
          ma1   <= mul32(sq_q, HASH_A_MUL);
          ma2   <= mul32({24'd0, ty_q}, HASH_A_TY);
          mb1   <= mul32(id_q, HASH_B_MUL);
          mb2   <= mul32({24'd0, ty_q}, HASH_B_TY);
          mc    <= mul32(hc0 ^ (hc0 >> 16), HASH_C_MUL1);
          state <= F_MUL2;
        end
        F_MUL2: begin
          ha       <= mul32(ha_mix, HASH_A_MUL);
          hb       <= mul32(hb_mix, HASH_B_MUL);
          hc       <= hc_mul ^ (hc_mul >> 16);
          step_cnt <= '0;
          state    <= IS_POW2 ? F_PUSH : F_MOD;
        end
        // quotient estimate, raw remainder, then correction
        F_MOD: begin
          if (step_cnt == STEP_W'(0)) begin
            rem_a <= quo_low(ha);
            rem_b <= quo_low(hb);
            rem_c <= quo_low(hc);
          end else if (step_cnt == STEP_W'(1)) begin
            rem_a <= rem_raw(ha, rem_a);
            rem_b <= rem_raw(hb, rem_b);
            rem_c <= rem_raw(hc, rem_c);
          end else begin
            rem_a <= rem_fix(rem_a);
            rem_b <= rem_fix(rem_b);
            rem_c <= rem_fix(rem_c);
            state <= F_PUSH;
          end
          step_cnt <= step_cnt + 1'b1;
        end
        F_PUSH: begin
          if (cmd_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  `RBD_CHECK_NEXT(a_rotate_restarts_slot, accept && rotate_now,
                  slot_start == $past(pkt.now_tick), "slot start not taken from rotating request")

endmodule

FILE: hw/rtl/rbd_cmd_fifo.sv
// Short queue of classified requests between front and back
module rbd_cmd_fifo
  import rbd_pkg::*;
#(
  parameter int unsigned DEPTH = CMD_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  rbd_cmd_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output rbd_cmd_t rd_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rbd_cmd_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/rbd_back.sv
// Back end: slot clearing, filter lookup and update, counters, result register
`include "rotating_bloom_dedup_unit_assert.svh"

module rbd_back
  import rbd_pkg::*;
#(
  parameter int unsigned FILTER_BITS = FILTER_BITS_DEF,
  parameter int unsigned NUM_SLOTS   = NUM_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  rbd_cmd_t cmd,
  output logic     init_busy,
  output logic     res_valid,
  input  logic     res_ready,
  output rbd_out_t res
);

  localparam int unsigned IDX_W  = $clog2(FILTER_BITS);
  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam logic [IDX_W:0] CLR_END = (IDX_W + 1)'(FILTER_BITS);

  typedef enum logic [9:0] {
    B_CLEAR = 10'b0000000001,
    B_IDLE  = 10'b0000000010,
    B_RD0   = 10'b0000000100,
    B_RD1   = 10'b0000001000,
    B_RD2   = 10'b0000010000,
    B_EVAL  = 10'b0000100000,
    B_WR0   = 10'b0001000000,
    B_WR1   = 10'b0010000000,
    B_WR2   = 10'b0100000000,
    B_OUT   = 10'b1000000000
  } back_state_t;

  back_state_t          state;
  logic [SLOT_W-1:0]    active_slot;
  logic [31:0]          inserts;
  logic [31:0]          dups;
  rbd_cmd_t             cmd_q;
  logic [NUM_SLOTS-1:0] row0, row1, row2;
  logic                 seen_q;
  logic                 clr_all;
  logic [IDX_W:0]       clr_rd;
  logic                 clr_pend;
  logic [IDX_W-1:0]     clr_addr;
  rbd_out_t             res_q;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [NUM_SLOTS-1:0] ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [NUM_SLOTS-1:0] ram_rdata;
  logic [NUM_SLOTS-1:0] slot_mask;
  logic [SLOT_W-1:0]    slot_next;
  logic [IDX_W-1:0]     p0, p1, p2;
  logic                 seen;
  logic                 res_load;

  // one row per bit position, one column per slot
  rbd_ram #(
    .WIDTH (NUM_SLOTS),
    .DEPTH (FILTER_BITS)
  ) u_bits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign p0        = cmd_q.pos0[IDX_W-1:0];
  assign p1        = cmd_q.pos1[IDX_W-1:0];
  assign p2        = cmd_q.pos2[IDX_W-1:0];
  assign slot_mask = NUM_SLOTS'(1) << active_slot;
  assign slot_next = (active_slot == SLOT_W'(NUM_SLOTS - 1)) ? '0 : active_slot + 1'b1;
  assign seen      = |(row0 & row1 & ram_rdata);
  assign cmd_ready = (state == B_IDLE);
  assign init_busy = (state == B_CLEAR) && clr_all;
  assign res       = res_q;
  assign res_load  = (state == B_OUT) && (!res_valid || res_ready);

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      B_CLEAR: begin
        ram_raddr = clr_rd[IDX_W-1:0];
        ram_we    = clr_pend;
        ram_waddr = clr_addr;
        ram_wdata = clr_all ? '0 : (ram_rdata & ~slot_mask);
      end
      B_RD0: ram_raddr = p0;
      B_RD1: ram_raddr = p1;
      B_RD2: ram_raddr = p2;
      B_WR0: begin
        ram_we    = 1'b1;
        ram_waddr = p0;
        ram_wdata = row0 | slot_mask;
      end
      B_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = p1;
        ram_wdata = row1 | slot_mask;
      end
      B_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = p2;
        ram_wdata = row2 | slot_mask;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_CLEAR;
      clr_all     <= 1'b1;
      clr_rd      <= '0;
      clr_pend    <= 1'b0;
      active_slot <= '0;
      inserts     <= '0;
      dups        <= '0;
      res_valid   <= 1'b0;
    end else begin
      // result register: load a new result, or drop the one taken
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        // read-modify-write sweep: read row n while writing row n-1
        B_CLEAR: begin
          clr_pend <= (clr_rd != CLR_END);
          clr_addr <= clr_rd[IDX_W-1:0];
          if (clr_rd != CLR_END) begin
            clr_rd <= clr_rd + 1'b1;
          end else if (!clr_pend) begin
            state <= clr_all ? B_IDLE : B_RD0;
          end
        end
        B_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd;
            if (cmd.rotate) begin
              active_slot <= slot_next;
              clr_all     <= 1'b0;
              clr_rd      <= '0;
              clr_pend    <= 1'b0;
              state       <= B_CLEAR;
            end else begin
              state <= B_RD0;
            end
          end
        end
        B_RD0: state <= B_RD1;
        B_RD1: begin
          row0  <= ram_rdata;
          state <= B_RD2;
        end
        B_RD2: begin
          row1  <= ram_rdata;
          state <= B_EVAL;
        end
        B_EVAL: begin
          row2   <= ram_rdata;
          seen_q <= seen;
          if (seen) begin
            dups  <= dups + 32'd1;
            state <= B_OUT;
          end else begin
            inserts <= inserts + 32'd1;
            state   <= B_WR0;
          end
        end
        B_WR0: state <= B_WR1;
        B_WR1: state <= B_WR2;
        B_WR2: state <= B_OUT;
        B_OUT: begin
          if (res_load) begin
            res_q.is_new       <= !seen_q;
            res_q.insert_count <= inserts;
            res_q.dup_count    <= dups;
            state              <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `RBD_CHECK_NEVER(a_no_write_when_idle, ram_we && (state == B_IDLE),
                   "filter RAM written while idle")
  `RBD_CHECK_IMPLY(a_insert_sets_active, ram_we && (state != B_CLEAR), ram_wdata[active_slot],
                   "insert does not set the active slot bit")
  `RBD_CHECK_NEXT(a_one_count_per_request, state == B_EVAL,
                  32'(inserts + dups) == 32'($past(inserts) + $past(dups) + 32'd1),
                  "counters did not advance by one request")

endmodule

FILE: hw/rtl/rotating_bloom_dedup_unit.sv
// Top level of the rotating Bloom dedup filter
// Duplicate-request filter built from NUM_SLOTS Bloom slots of FILTER_BITS bits, held in
// one RAM of FILTER_BITS rows by NUM_SLOTS columns. Each request gives one result: is_new
// plus the running insert and duplicate counts. The front end takes a request, runs two
// hash multiply stages and then reduces the three hashes modulo FILTER_BITS by a reciprocal
// multiply, a multiply-subtract and one correcting subtract (skipped when FILTER_BITS is a
// power of two); it takes no new request until the last one is pushed into the queue. A
// two-entry queue sits between front and back. The back end handles one request at a time
// and is bound by the single read and single write port of the filter RAM. When a request
// rotates to a new slot, that slot's column is first cleared row by row. After reset the
// whole RAM is cleared in one pass during which pkt_ready stays low; writes to window_ticks
// through cfg_we are taken at any time.
module rotating_bloom_dedup_unit
  import rbd_pkg::*;
#(
  parameter int unsigned FILTER_BITS = FILTER_BITS_DEF,
  parameter int unsigned NUM_SLOTS   = NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        pkt_valid,
  output logic        pkt_ready,
  input  rbd_in_t     pkt,
  output logic        res_valid,
  input  logic        res_ready,
  output rbd_out_t    res
);

  logic     init_busy;
  logic     fq_wr_valid;
  logic     fq_wr_ready;
  rbd_cmd_t fq_wr_data;
  logic     fq_rd_valid;
  logic     fq_rd_ready;
  rbd_cmd_t fq_rd_data;

  // hashing and rotation decision
  rbd_front #(
    .FILTER_BITS (FILTER_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .init_busy (init_busy),
    .cmd_valid (fq_wr_valid),
    .cmd_ready (fq_wr_ready),
    .cmd       (fq_wr_data)
  );

  // request queue
  rbd_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_wr_valid),
    .wr_ready (fq_wr_ready),
    .wr_data  (fq_wr_data),
    .rd_valid (fq_rd_valid),
    .rd_ready (fq_rd_ready),
    .rd_data  (fq_rd_data)
  );

  // filter lookup and update
  rbd_back #(
    .FILTER_BITS (FILTER_BITS),
    .NUM_SLOTS   (NUM_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (fq_rd_valid),
    .cmd_ready (fq_rd_ready),
    .cmd       (fq_rd_data),
    .init_busy (init_busy),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
